FILE: rtl/mfw_pkg.sv
// Package for the clipped-window median filter: sequencer states, register
// indexes, input operation codes and the fixed field widths.
// No dependencies.
package mfw_pkg;

  localparam int MAX_WINDOW_DEF = 7;
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int PIXEL_BITS_DEF = 8;

  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int DIM_W      = 13;
  localparam int LIN_W      = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd2;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_BOUNDS,
    ST_ORIGIN,
    ST_GATHER,
    ST_CAPTURE,
    ST_SELECT,
    ST_LOAD
  } state_t;

endpackage

FILE: rtl/median_filter_window.sv
// Clipped-window 2-D median filter over a raster pixel stream.
// A request is taken only while the sequencer is idle, so a new request waits until the last one is
// done: a request that yields a result gathers its clipped window (up to 49 cells) through the single
// line store read port, runs the bit-serial selector and waits for the output register to be free.
// Reset (rst_n, synchronous, active low) clears the sequencer, position counters and config
// to window 3, 1024 x 768. The line store is not cleared and needs no clearing pass.
module median_filter_window
  import mfw_pkg::*;
#(
  parameter int MAX_WINDOW = mfw_pkg::MAX_WINDOW_DEF,
  parameter int MAX_WIDTH  = mfw_pkg::MAX_WIDTH_DEF,
  parameter int PIXEL_BITS = mfw_pkg::PIXEL_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_op,
  input  logic [7:0]                       in_pixel,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [7:0]                       out_median,
  output logic                             out_frame_last,
  input  logic                             cfg_we,
  input  logic [mfw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mfw_pkg::CFG_DATA_W-1:0]   cfg_data
);

  // Geometry derived from the parameters. The line store holds enough recent pixels to cover
  // every row of the tallest window at the widest frame.
  localparam int HALF_MAX = MAX_WINDOW / 2;
  localparam int WIN_SIDE = 2 * HALF_MAX + 1;
  localparam int CELLS    = WIN_SIDE * WIN_SIDE;
  localparam int RING     = 2 * HALF_MAX * MAX_WIDTH + 2 * HALF_MAX + 1;
  localparam int AW       = (RING > 1) ? $clog2(RING) : 1;
  localparam int PB       = (PIXEL_BITS < 8) ? PIXEL_BITS : 8;
  localparam int HW       = (HALF_MAX > 0) ? $clog2(HALF_MAX + 1) : 1;
  localparam int CW       = $clog2(CELLS + 1);
  localparam int SW       = $clog2(WIN_SIDE + 1);
  localparam int BW       = (PB > 1) ? $clog2(PB) : 1;
  localparam int PW       = ((AW > DIM_W) ? AW : DIM_W) + 1;

  // Configuration registers and the effective values the datapath works with.
  logic [2:0]       ws_r;
  logic [10:0]      fw_r;
  logic [12:0]      fh_r;
  logic [DIM_W-1:0] w_eff, hgt_eff;
  logic [3:0]       ws_sat;
  logic [HW-1:0]    h_eff;
  logic [LIN_W-1:0] total_r, lag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r <= 3'd3;
      fw_r <= 11'd1024;
      fh_r <= 13'd768;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WINDOW_SIZE:  ws_r <= cfg_data[2:0];
        CFG_FRAME_WIDTH:  fw_r <= cfg_data[10:0];
        CFG_FRAME_HEIGHT: fh_r <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (fw_r == 11'd0) begin
      w_eff = DIM_W'(1);
    end else if (DIM_W'(fw_r) > DIM_W'(MAX_WIDTH)) begin
      w_eff = DIM_W'(MAX_WIDTH);
    end else begin
      w_eff = DIM_W'(fw_r);
    end
    hgt_eff = (fh_r == 13'd0) ? DIM_W'(1) : DIM_W'(fh_r);
    ws_sat  = (4'(ws_r) > 4'(MAX_WINDOW)) ? 4'(MAX_WINDOW) : 4'(ws_r);
    h_eff   = HW'(ws_sat >> 1);
  end

  // Frame size and output lag are registered every cycle; the sequencer first reads them in the
  // cycle after a request is taken, so a write just before a request is already seen.
  always_ff @(posedge clk) begin
    total_r <= LIN_W'(w_eff * hgt_eff);
    lag_r   <= LIN_W'(LIN_W'(h_eff) * LIN_W'(w_eff) + LIN_W'(h_eff));
  end

  // Sequencer.
  state_t state_r, state_nxt;

  logic             op_r;
  logic [PB-1:0]    pix_r;

  // Position counters for the incoming and outgoing pixel, with their linear index and
  // their address in the line store.
  logic [DIM_W-1:0] in_row_r, in_col_r, out_row_r, out_col_r;
  logic [LIN_W-1:0] in_lin_r, out_lin_r;
  logic [AW-1:0]    wr_ptr_r, out_ptr_r;

  // Window gathering.
  logic [HW-1:0]    dr_r, dc_r;
  logic [SW-1:0]    nrow_r, ncol_r, gi_r, gj_r;
  logic [AW-1:0]    rd_addr_r, row_ptr_r;
  logic             rd_vld_r;
  logic [PB-1:0]    rd_data_r;
  logic [PB-1:0]    win_r [CELLS];
  logic [CW-1:0]    n_r;

  // Bit-serial selection.
  logic [CELLS-1:0] act_r;
  logic [CW-1:0]    rank_r;
  logic [BW-1:0]    bit_r;
  logic [PB-1:0]    res_r;

  logic             out_valid_r, out_last_r;
  logic [7:0]       out_median_r;

  // Line store, one write and one registered read per cycle.
  logic [PB-1:0]    mem [RING];
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= pix_r;
    end
    rd_data_r <= mem[rd_addr_r];
  end

  // Pixel request handling: a pixel after a complete frame starts a new frame.
  logic             restart;
  logic [DIM_W-1:0] ir, ic, ic_inc;
  logic [LIN_W-1:0] il, ol, n_new;
  logic [AW-1:0]    wp, wp_inc;
  logic             emit_pix, emit_flush, emit;

  // Window bounds, origin and read pointer stepping.
  logic [HW-1:0]    dr, dc, dd, dcr;
  logic [DIM_W-1:0] rows_below, cols_right;
  logic [PW-1:0]    off, start_sum, step_sum;
  logic [AW-1:0]    start_ptr, row_next, addr_inc, out_ptr_inc;
  logic             last_cell, row_end;

  // Selection step.
  logic [CELLS-1:0] zero_m;
  logic [CW-1:0]    cnt0;
  logic             take_zero;

  logic             out_free, last_pix;
  logic [DIM_W-1:0] oc_inc;

  always_comb begin
    restart  = (in_row_r >= hgt_eff);
    ir       = restart ? '0 : in_row_r;
    ic       = restart ? '0 : in_col_r;
    il       = restart ? '0 : in_lin_r;
    ol       = restart ? '0 : out_lin_r;
    wp       = restart ? '0 : wr_ptr_r;
    wp_inc   = (wp == AW'(RING - 1)) ? '0 : wp + AW'(1);
    ic_inc   = ic + DIM_W'(1);
    n_new    = il + LIN_W'(1);
    emit_pix = (ol < total_r) &&
               ({1'b0, n_new} > ({1'b0, ol} + {1'b0, lag_r}));
    emit_flush = !(in_row_r < hgt_eff) && (out_lin_r < total_r);
    emit     = (op_r == OP_FLUSH) ? emit_flush : emit_pix;
  end

  always_comb begin
    rows_below = hgt_eff - DIM_W'(1) - out_row_r;
    cols_right = w_eff - DIM_W'(1) - out_col_r;
    dr  = (out_row_r >= DIM_W'(h_eff)) ? h_eff : HW'(out_row_r);
    dc  = (out_col_r >= DIM_W'(h_eff)) ? h_eff : HW'(out_col_r);
    dd  = (rows_below < DIM_W'(h_eff)) ? HW'(rows_below) : h_eff;
    dcr = (cols_right < DIM_W'(h_eff)) ? HW'(cols_right) : h_eff;

    off       = PW'(PW'(dr_r) * PW'(w_eff) + PW'(dc_r));
    start_sum = PW'(out_ptr_r) - off;
    start_ptr = (PW'(out_ptr_r) >= off) ? AW'(start_sum)
                                        : AW'(start_sum + PW'(RING));

    step_sum  = PW'(row_ptr_r) + PW'(w_eff);
    row_next  = (step_sum >= PW'(RING)) ? AW'(step_sum - PW'(RING)) : AW'(step_sum);
    addr_inc  = (rd_addr_r == AW'(RING - 1)) ? '0 : rd_addr_r + AW'(1);
    row_end   = (gj_r == ncol_r - SW'(1));
    last_cell = row_end && (gi_r == nrow_r - SW'(1));
  end

  always_comb begin
    cnt0 = '0;
    for (int l = 0; l < CELLS; l++) begin
      zero_m[l] = act_r[l] & ~win_r[l][bit_r];
      cnt0      = cnt0 + CW'(zero_m[l]);
    end
    take_zero = (rank_r < cnt0);
  end

  always_comb begin
    out_free    = !out_valid_r || out_ready;
    last_pix    = ((out_lin_r + LIN_W'(1)) >= total_r);
    oc_inc      = out_col_r + DIM_W'(1);
    out_ptr_inc = (out_ptr_r == AW'(RING - 1)) ? '0 : out_ptr_r + AW'(1);
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:    if (in_valid) state_nxt = ST_EXEC;
      ST_EXEC:    state_nxt = emit ? ST_BOUNDS : ST_IDLE;
      ST_BOUNDS:  state_nxt = ST_ORIGIN;
      ST_ORIGIN:  state_nxt = ST_GATHER;
      ST_GATHER:  if (last_cell) state_nxt = ST_CAPTURE;
      ST_CAPTURE: state_nxt = ST_SELECT;
      ST_SELECT:  if (rd_vld_r == 1'b0 && bit_r == '0) state_nxt = ST_LOAD;
      ST_LOAD:    if (out_free) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_ready  = (state_r == ST_IDLE);
    mem_we    = (state_r == ST_EXEC) && (op_r == OP_PIXEL);
    mem_waddr = wp;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Position counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_row_r  <= '0;
      in_col_r  <= '0;
      in_lin_r  <= '0;
      wr_ptr_r  <= '0;
      out_row_r <= '0;
      out_col_r <= '0;
      out_lin_r <= '0;
      out_ptr_r <= '0;
    end else if (state_r == ST_EXEC && op_r == OP_PIXEL) begin
      in_lin_r <= n_new;
      wr_ptr_r <= wp_inc;
      if (ic_inc >= w_eff) begin
        in_col_r <= '0;
        in_row_r <= ir + DIM_W'(1);
      end else begin
        in_col_r <= ic_inc;
        in_row_r <= ir;
      end
      if (restart) begin
        out_row_r <= '0;
        out_col_r <= '0;
        out_lin_r <= '0;
        out_ptr_r <= '0;
      end
    end else if (state_r == ST_LOAD && out_free) begin
      if (last_pix) begin
        in_row_r  <= '0;
        in_col_r  <= '0;
        in_lin_r  <= '0;
        wr_ptr_r  <= '0;
        out_row_r <= '0;
        out_col_r <= '0;
        out_lin_r <= '0;
        out_ptr_r <= '0;
      end else begin
        out_lin_r <= out_lin_r + LIN_W'(1);
        out_ptr_r <= out_ptr_inc;
        if (oc_inc >= w_eff) begin
          out_col_r <= '0;
          out_row_r <= out_row_r + DIM_W'(1);
        end else begin
          out_col_r <= oc_inc;
        end
      end
    end
  end

  // Gather and select datapath.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= (state_r == ST_GATHER);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      op_r  <= in_op;
      pix_r <= PB'(in_pixel);
    end

    if (state_r == ST_BOUNDS) begin
      dr_r   <= dr;
      dc_r   <= dc;
      nrow_r <= SW'(dr) + SW'(dd) + SW'(1);
      ncol_r <= SW'(dc) + SW'(dcr) + SW'(1);
    end

    if (state_r == ST_ORIGIN) begin
      rd_addr_r <= start_ptr;
      row_ptr_r <= start_ptr;
      gi_r      <= '0;
      gj_r      <= '0;
      n_r       <= '0;
    end else if (state_r == ST_GATHER) begin
      if (row_end) begin
        gj_r      <= '0;
        gi_r      <= gi_r + SW'(1);
        row_ptr_r <= row_next;
        rd_addr_r <= row_next;
      end else begin
        gj_r      <= gj_r + SW'(1);
        rd_addr_r <= addr_inc;
      end
    end

    if (rd_vld_r) begin
      win_r[n_r[CW-1:0]] <= rd_data_r;
      n_r                <= n_r + CW'(1);
    end

    // Selection is set up in the capture cycle, while the last read lands in the window
    // registers; n_r still counts one cell short there.
    if (state_r == ST_CAPTURE) begin
      for (int l = 0; l < CELLS; l++) begin
        act_r[l] <= (CW'(l) < n_r + CW'(1));
      end
      rank_r <= CW'(n_r >> 1);
      bit_r  <= BW'(PB - 1);
      res_r  <= '0;
    end else if (state_r == ST_SELECT) begin
      if (take_zero) begin
        act_r <= zero_m;
      end else begin
        act_r  <= act_r & ~zero_m;
        rank_r <= rank_r - cnt0;
      end
      res_r[bit_r] <= !take_zero;
      if (bit_r != '0) begin
        bit_r <= bit_r - BW'(1);
      end
    end
  end

  // Output register: the block takes the next request while a result waits here.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_LOAD && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_LOAD && out_free) begin
      out_median_r <= 8'(res_r);
      out_last_r   <= last_pix;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_median     = out_median_r;
  assign out_frame_last = out_last_r;

endmodule
